[hw/rtl/rcaa_pkg.sv]
// ----------------------------------------------------------------------------
// rcaa_pkg: shared types and constants for the rounded corner mask
//
// Register indexes, field widths, subsample grid offsets and the wide
// square/sum widths used by the coverage pipeline.
// ----------------------------------------------------------------------------
package rcaa_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    // Field widths
    localparam int DIM_W   = 14;  // window width / height registers
    localparam int RAD_W   = 13;  // corner radius register and local offsets
    localparam int COORD_W = 13;  // pixel coordinates
    localparam int CFG_W   = 14;  // widest register
    localparam int BYTE_W  = 8;
    localparam int NUM_BYTES = 4;

    // Subsample grid: 4 per axis, odd offsets in eighth-pixel units
    localparam int SUBSAMPLES = 4;
    localparam int COV_W      = 5;   // 0..16
    localparam int ROW_CNT_W  = 3;   // 0..4

    // Squares of local offsets (up to about 16 bits squared)
    localparam int RSQ_W = 2 * RAD_W;  // a*a, b*b, r*r
    localparam int SQ_W  = 32;         // (8a+o)^2 and (8r)^2
    localparam int SUM_W = SQ_W + 1;

    localparam logic [2:0] SUB_OFS [SUBSAMPLES] = '{3'd1, 3'd3, 3'd5, 3'd7};

    typedef logic [NUM_BYTES-1:0][BYTE_W-1:0] pix_t;
    typedef logic [RAD_W-1:0]                 loc_t;
    typedef logic [SQ_W-1:0]                  sq_t;

    // (8*a + o)^2 = 64*a^2 + 16*a*o + o^2, with a^2 already computed
    function automatic sq_t offset_square(input loc_t a, input logic [RSQ_W-1:0] a_sq,
                                          input logic [2:0] o);
        sq_t lin;
        sq_t cst;
        lin = SQ_W'(a) * SQ_W'(o);
        cst = SQ_W'(o) * SQ_W'(o);
        return (SQ_W'(a_sq) << 6) + (lin << 4) + cst;
    endfunction

endpackage

[hw/rtl/rounded_corner_aa_mask.sv]
// ----------------------------------------------------------------------------
// rounded_corner_aa_mask: anti-aliased rounded corner alpha mask
//
// Scales each premultiplied pixel by its 4x4 supersampled coverage against
// circular arcs in the four window corners.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while in_stall is low. The work runs
// through five register stages: corner classification, local squares,
// subsample distances, per-row hit counts, and coverage scaling into the
// output register. A stall on the output freezes all stages together, so
// in_stall follows out_stall while the output register holds a result.
// Configuration writes take effect for the next pixel accepted; a radius
// of zero, or a radius whose double exceeds the width or height, passes
// every pixel unchanged.
module rounded_corner_aa_mask
    import rcaa_pkg::*;
#(
    parameter int MAX_DIM = 8192
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [COORD_W-1:0] pixel_x,
    input  logic [COORD_W-1:0] pixel_y,
    input  logic [BYTE_W-1:0]  in_byte0,
    input  logic [BYTE_W-1:0]  in_byte1,
    input  logic [BYTE_W-1:0]  in_byte2,
    input  logic [BYTE_W-1:0]  in_byte3,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [BYTE_W-1:0]  out_byte0,
    output logic [BYTE_W-1:0]  out_byte1,
    output logic [BYTE_W-1:0]  out_byte2,
    output logic [BYTE_W-1:0]  out_byte3
);

    // Dimension clamp; a limit beyond the register range never applies
    localparam logic [DIM_W-1:0] DIM_LIMIT =
        (MAX_DIM >= (1 << DIM_W) - 1) ? {DIM_W{1'b1}} : DIM_W'(MAX_DIM);

    // Configuration registers
    logic [DIM_W-1:0] window_width_reg;
    logic [DIM_W-1:0] window_height_reg;
    loc_t             corner_radius_reg;

    // Pipeline control
    logic advance;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;

    // Stage 1: classification
    logic s1_corner_next, s1_corner_reg;
    loc_t s1_a_next, s1_a_reg;
    loc_t s1_b_next, s1_b_reg;
    loc_t s1_r_reg;
    pix_t s1_pix_reg;

    // Stage 2: squares
    logic             s2_corner_reg;
    loc_t             s2_a_reg, s2_b_reg;
    logic [RSQ_W-1:0] s2_asq_reg, s2_bsq_reg, s2_rsq_reg;
    pix_t             s2_pix_reg;

    // Stage 3: subsample distances
    logic s3_corner_reg;
    sq_t  s3_xsq_reg [SUBSAMPLES];
    sq_t  s3_ysq_reg [SUBSAMPLES];
    sq_t  s3_lim_reg;
    pix_t s3_pix_reg;

    // Stage 4: per-row hit counts
    logic                 s4_corner_reg;
    logic [ROW_CNT_W-1:0] s4_row_next [SUBSAMPLES];
    logic [ROW_CNT_W-1:0] s4_row_reg  [SUBSAMPLES];
    pix_t                 s4_pix_reg;

    // Output stage
    pix_t out_pix_next, out_pix_reg;

    // ------------------------------------------------------------------
    // Configuration writes; unknown indexes drop
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_width_reg  <= DIM_W'(1);
            window_height_reg <= DIM_W'(1);
            corner_radius_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:  window_width_reg  <= cfg_data;
                REG_HEIGHT: window_height_reg <= cfg_data;
                REG_RADIUS: corner_radius_reg <= cfg_data[RAD_W-1:0];
                default:    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Advance all stages unless a held result is stalled
    // ------------------------------------------------------------------
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: find the corner box and fold the pixel into local offsets
    // measured from the arc center, so all four corners look alike
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [DIM_W-1:0] two_r;
        logic [DIM_W-1:0] r_ext;
        logic [DIM_W-1:0] x_ext;
        logic [DIM_W-1:0] y_ext;
        logic [DIM_W-1:0] w_minus_r;
        logic [DIM_W-1:0] h_minus_r;
        logic             enable;
        logic             left, right, top, bottom;

        w         = (window_width_reg  > DIM_LIMIT) ? DIM_LIMIT : window_width_reg;
        h         = (window_height_reg > DIM_LIMIT) ? DIM_LIMIT : window_height_reg;
        r_ext     = {1'b0, corner_radius_reg};
        two_r     = {corner_radius_reg, 1'b0};
        x_ext     = {1'b0, pixel_x};
        y_ext     = {1'b0, pixel_y};
        w_minus_r = w - r_ext;
        h_minus_r = h - r_ext;

        enable = (corner_radius_reg != '0) && (two_r <= w) && (two_r <= h)
                 && (x_ext < w) && (y_ext < h);
        left   = x_ext < r_ext;
        right  = x_ext >= w_minus_r;
        top    = y_ext < r_ext;
        bottom = y_ext >= h_minus_r;

        s1_corner_next = enable && (left || right) && (top || bottom);
        s1_a_next = left ? RAD_W'(r_ext - x_ext - DIM_W'(1)) : RAD_W'(x_ext - w_minus_r);
        s1_b_next = top  ? RAD_W'(r_ext - y_ext - DIM_W'(1)) : RAD_W'(y_ext - h_minus_r);
    end

    // ------------------------------------------------------------------
    // Stage 4 row counts: compare each subsample distance with the radius
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [SUM_W-1:0] dist_sum;
        for (int i = 0; i < SUBSAMPLES; i++)
        begin
            s4_row_next[i] = '0;
            for (int j = 0; j < SUBSAMPLES; j++)
            begin
                dist_sum = SUM_W'(s3_ysq_reg[i]) + SUM_W'(s3_xsq_reg[j]);
                if (dist_sum <= SUM_W'(s3_lim_reg))
                    s4_row_next[i] = s4_row_next[i] + ROW_CNT_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: total coverage, scale each byte by coverage / 16;
    // zero coverage clears and full coverage keeps the byte
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [COV_W-1:0]        cov;
        logic [BYTE_W+COV_W-1:0] prod;
        cov = '0;
        for (int i = 0; i < SUBSAMPLES; i++)
            cov = cov + COV_W'(s4_row_reg[i]);
        if (!s4_corner_reg)
            cov = COV_W'(SUBSAMPLES * SUBSAMPLES);
        for (int k = 0; k < NUM_BYTES; k++)
        begin
            prod            = (BYTE_W + COV_W)'(s4_pix_reg[k]) * (BYTE_W + COV_W)'(cov);
            out_pix_next[k] = prod[BYTE_W+3:4];
        end
    end

    // ------------------------------------------------------------------
    // Payload registers; hold while stalled
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            // Stage 1
            s1_corner_reg <= s1_corner_next;
            s1_a_reg      <= s1_a_next;
            s1_b_reg      <= s1_b_next;
            s1_r_reg      <= corner_radius_reg;
            s1_pix_reg    <= {in_byte3, in_byte2, in_byte1, in_byte0};

            // Stage 2: squares of local offsets and radius
            s2_corner_reg <= s1_corner_reg;
            s2_a_reg      <= s1_a_reg;
            s2_b_reg      <= s1_b_reg;
            s2_asq_reg    <= RSQ_W'(s1_a_reg) * RSQ_W'(s1_a_reg);
            s2_bsq_reg    <= RSQ_W'(s1_b_reg) * RSQ_W'(s1_b_reg);
            s2_rsq_reg    <= RSQ_W'(s1_r_reg) * RSQ_W'(s1_r_reg);
            s2_pix_reg    <= s1_pix_reg;

            // Stage 3: squared subsample distances along each axis
            s3_corner_reg <= s2_corner_reg;
            for (int i = 0; i < SUBSAMPLES; i++)
            begin
                s3_xsq_reg[i] <= offset_square(s2_a_reg, s2_asq_reg, SUB_OFS[i]);
                s3_ysq_reg[i] <= offset_square(s2_b_reg, s2_bsq_reg, SUB_OFS[i]);
            end
            s3_lim_reg    <= SQ_W'(s2_rsq_reg) << 6;
            s3_pix_reg    <= s2_pix_reg;

            // Stage 4
            s4_corner_reg <= s3_corner_reg;
            s4_row_reg    <= s4_row_next;
            s4_pix_reg    <= s3_pix_reg;

            // Output
            out_pix_reg   <= out_pix_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte0 = out_pix_reg[0];
    assign out_byte1 = out_pix_reg[1];
    assign out_byte2 = out_pix_reg[2];
    assign out_byte3 = out_pix_reg[3];

endmodule
